/* hdl/terminal_key_sequence_encoder_top_assert.svh */
// Assertion macros of the terminal key sequence encoder, used by tkse_back.
// No dependencies; the bodies vanish when SYNTHESIS is defined.
`ifndef TERMINAL_KEY_SEQUENCE_ENCODER_TOP_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TKSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tkse assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define TKSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tkse assertion failed");
`else
`define TKSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TKSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tkse_pkg.sv */
// Types, key codes and lookup functions of the terminal key sequence encoder.
// No dependencies; used by every module of the block.
package tkse_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_BYTES   = 7;

    localparam logic [4:0] KEY_CHAR      = 5'd1;
    localparam logic [4:0] KEY_ENTER     = 5'd2;
    localparam logic [4:0] KEY_TAB       = 5'd3;
    localparam logic [4:0] KEY_BACKSPACE = 5'd4;
    localparam logic [4:0] KEY_ESCAPE    = 5'd5;
    localparam logic [4:0] KEY_UP        = 5'd6;
    localparam logic [4:0] KEY_BACKTAB   = 5'd16;
    localparam logic [4:0] KEY_INSERT    = 5'd17;
    localparam logic [4:0] KEY_F12       = 5'd28;

    localparam int MOD_SHIFT = 0;
    localparam int MOD_ALT   = 1;
    localparam int MOD_CTRL  = 2;

    localparam logic [1:0] FORM_APP = 2'd0;
    localparam logic [1:0] FORM_SS3 = 2'd1;
    localparam logic [1:0] FORM_CSI = 2'd2;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;
    localparam logic [7:0] BYTE_SS3   = 8'h4F;
    localparam logic [7:0] BYTE_ONE   = 8'h31;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;

    typedef struct packed {
        logic [4:0]  key_code;
        logic [20:0] code_point;
        logic [2:0]  modifier_mask;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out;

    // One decoded key: its bytes in order from index 0, and how many there are.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
    } t_cmd;

    function automatic logic [7:0] f_single(input logic [4:0] key);
        logic [7:0] r;
        case (key)
            KEY_ENTER:     r = 8'h0D;
            KEY_TAB:       r = 8'h09;
            KEY_BACKSPACE: r = 8'h7F;
            default:       r = BYTE_ESC;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_letter_final(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0:    r = "A";
            4'd1:    r = "B";
            4'd2:    r = "C";
            4'd3:    r = "D";
            4'd4:    r = "H";
            4'd5:    r = "F";
            4'd6:    r = "P";
            4'd7:    r = "Q";
            4'd8:    r = "R";
            4'd9:    r = "S";
            default: r = "Z";
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_letter_form(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: r = FORM_APP;
            4'd6, 4'd7, 4'd8, 4'd9:             r = FORM_SS3;
            default:                            r = FORM_CSI;
        endcase
        return r;
    endfunction

    // Numeric code of a tilde key as two decimal digits, tens then units.
    function automatic logic [7:0] f_tilde_bcd(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0:    r = 8'h02;
            4'd1:    r = 8'h03;
            4'd2:    r = 8'h05;
            4'd3:    r = 8'h06;
            4'd4:    r = 8'h15;
            4'd5:    r = 8'h17;
            4'd6:    r = 8'h18;
            4'd7:    r = 8'h19;
            4'd8:    r = 8'h20;
            4'd9:    r = 8'h21;
            4'd10:   r = 8'h23;
            default: r = 8'h24;
        endcase
        return r;
    endfunction

endpackage

/* hdl/tkse_front.sv */
// Front end: takes key items, holds the cursor mode register and decodes each
// item into its complete byte sequence for the queue. Depends on tkse_pkg.
module tkse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_push,
    input  tkse_pkg::t_in  i_item,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_q_push,
    output tkse_pkg::t_cmd o_cmd
);

    logic                                 r_app_mode;
    logic                                 n_app_mode;
    logic [tkse_pkg::MAX_BYTES-1:0][7:0]  v_bytes;
    logic [2:0]                           v_n;
    logic [20:0]                          v_cp;
    logic [3:0]                           v_k;
    logic [7:0]                           v_bcd;
    logic [7:0]                           v_mod_digit;
    logic                                 v_ctrl_letter;

    always_comb begin
        n_app_mode = i_cfg_we ? i_cfg_wdata : r_app_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_mode <= 1'b0;
        end else begin
            r_app_mode <= n_app_mode;
        end
    end

    // Code points beyond the Unicode range and surrogates go out as U+FFFD.
    assign v_cp = (i_item.code_point > 21'h10FFFF ||
                   (i_item.code_point >= 21'h00D800 && i_item.code_point <= 21'h00DFFF))
                  ? 21'h00FFFD : i_item.code_point;

    assign v_ctrl_letter = (i_item.code_point >= 21'h61 && i_item.code_point <= 21'h7A) ||
                           (i_item.code_point >= 21'h41 && i_item.code_point <= 21'h5A);

    assign v_mod_digit = tkse_pkg::BYTE_ONE + {5'd0, i_item.modifier_mask};

    always_comb begin
        v_bytes = '0;
        v_n     = 3'd0;
        v_k     = 4'd0;
        v_bcd   = 8'd0;
        if (i_item.key_code == tkse_pkg::KEY_CHAR) begin
            if (i_item.modifier_mask[tkse_pkg::MOD_ALT]) begin
                v_bytes[v_n] = tkse_pkg::BYTE_ESC;
                v_n = v_n + 3'd1;
            end
            if (i_item.modifier_mask[tkse_pkg::MOD_CTRL] && v_ctrl_letter) begin
                // Both cases of a letter share their low five bits: 1 to 26.
                v_bytes[v_n] = {3'd0, i_item.code_point[4:0]};
                v_n = v_n + 3'd1;
            end else if (i_item.modifier_mask[tkse_pkg::MOD_CTRL] &&
                         i_item.code_point == 21'h20) begin
                v_bytes[v_n] = 8'h00;
                v_n = v_n + 3'd1;
            end else if (v_cp < 21'h80) begin
                v_bytes[v_n] = v_cp[7:0];
                v_n = v_n + 3'd1;
            end else if (v_cp < 21'h800) begin
                v_bytes[v_n] = {3'b110, v_cp[10:6]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[5:0]};
                v_n = v_n + 3'd1;
            end else if (v_cp < 21'h10000) begin
                v_bytes[v_n] = {4'b1110, v_cp[15:12]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[11:6]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[5:0]};
                v_n = v_n + 3'd1;
            end else begin
                v_bytes[v_n] = {5'b11110, v_cp[20:18]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[17:12]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[11:6]};
                v_n = v_n + 3'd1;
                v_bytes[v_n] = {2'b10, v_cp[5:0]};
                v_n = v_n + 3'd1;
            end
        end else if (i_item.key_code inside {[tkse_pkg::KEY_ENTER:tkse_pkg::KEY_ESCAPE]}) begin
            if (i_item.modifier_mask[tkse_pkg::MOD_ALT]) begin
                v_bytes[v_n] = tkse_pkg::BYTE_ESC;
                v_n = v_n + 3'd1;
            end
            v_bytes[v_n] = tkse_pkg::f_single(i_item.key_code);
            v_n = v_n + 3'd1;
        end else if (i_item.key_code inside {[tkse_pkg::KEY_UP:tkse_pkg::KEY_BACKTAB]}) begin
            v_k = 4'(i_item.key_code - tkse_pkg::KEY_UP);
            v_bytes[v_n] = tkse_pkg::BYTE_ESC;
            v_n = v_n + 3'd1;
            if (i_item.modifier_mask != 3'd0) begin
                v_bytes[v_n] = tkse_pkg::BYTE_CSI;
                v_n = v_n + 3'd1;
                v_bytes[v_n] = tkse_pkg::BYTE_ONE;
                v_n = v_n + 3'd1;
                v_bytes[v_n] = tkse_pkg::BYTE_SEMI;
                v_n = v_n + 3'd1;
                v_bytes[v_n] = v_mod_digit;
                v_n = v_n + 3'd1;
            end else if (tkse_pkg::f_letter_form(v_k) == tkse_pkg::FORM_SS3 ||
                         (tkse_pkg::f_letter_form(v_k) == tkse_pkg::FORM_APP && r_app_mode)) begin
                v_bytes[v_n] = tkse_pkg::BYTE_SS3;
                v_n = v_n + 3'd1;
            end else begin
                v_bytes[v_n] = tkse_pkg::BYTE_CSI;
                v_n = v_n + 3'd1;
            end
            v_bytes[v_n] = tkse_pkg::f_letter_final(v_k);
            v_n = v_n + 3'd1;
        end else if (i_item.key_code inside {[tkse_pkg::KEY_INSERT:tkse_pkg::KEY_F12]}) begin
            v_k   = 4'(i_item.key_code - tkse_pkg::KEY_INSERT);
            v_bcd = tkse_pkg::f_tilde_bcd(v_k);
            v_bytes[v_n] = tkse_pkg::BYTE_ESC;
            v_n = v_n + 3'd1;
            v_bytes[v_n] = tkse_pkg::BYTE_CSI;
            v_n = v_n + 3'd1;
            if (v_bcd[7:4] != 4'd0) begin
                v_bytes[v_n] = tkse_pkg::BYTE_ZERO | {4'd0, v_bcd[7:4]};
                v_n = v_n + 3'd1;
            end
            v_bytes[v_n] = tkse_pkg::BYTE_ZERO | {4'd0, v_bcd[3:0]};
            v_n = v_n + 3'd1;
            if (i_item.modifier_mask != 3'd0) begin
                v_bytes[v_n] = tkse_pkg::BYTE_SEMI;
                v_n = v_n + 3'd1;
                v_bytes[v_n] = v_mod_digit;
                v_n = v_n + 3'd1;
            end
            v_bytes[v_n] = tkse_pkg::BYTE_TILDE;
            v_n = v_n + 3'd1;
        end
    end

    assign o_full       = i_q_full;
    // Items that produce no bytes are taken and dropped here.
    assign o_q_push     = i_push && !i_q_full && (v_n != 3'd0);
    assign o_cmd.bytes  = v_bytes;
    assign o_cmd.len    = v_n;

endmodule

/* hdl/tkse_queue.sv */
// Short queue of decoded key sequences between the front and back ends.
// Depends on tkse_pkg for the entry type.
module tkse_queue #(
    parameter int DEPTH = tkse_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tkse_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tkse_pkg::t_cmd o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tkse_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             v_wr;
    logic             v_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign v_wr    = i_push && !o_full;
    assign v_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (v_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (v_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (v_wr && !v_rd) begin
            n_count = r_count + 1'b1;
        end else if (v_rd && !v_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/tkse_back.sv */
// Back end: walks the byte sequence at the queue head one byte a cycle into the
// output register while it is free. Depends on tkse_pkg and the assertion macro header.
`include "terminal_key_sequence_encoder_top_assert.svh"

module tkse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tkse_pkg::t_cmd i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output tkse_pkg::t_out o_result
);

    logic [2:0]     r_idx;
    logic [2:0]     n_idx;
    logic           r_out_valid;
    logic           n_out_valid;
    tkse_pkg::t_out r_out;
    tkse_pkg::t_out n_out;
    logic           v_slot_free;
    logic           v_emit;
    logic           v_last;

    // The output register takes a new byte whenever it is empty or being drained.
    assign v_slot_free = !r_out_valid || i_pop;
    assign v_emit      = !i_q_empty && v_slot_free;
    assign v_last      = (r_idx == i_head.len - 3'd1);
    assign o_q_pop     = v_emit && v_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (v_emit) begin
            n_out.out_byte  = i_head.bytes[r_idx];
            n_out.last_byte = v_last;
            n_out_valid     = 1'b1;
            n_idx           = v_last ? 3'd0 : r_idx + 3'd1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `TKSE_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, !i_q_empty, r_idx < i_head.len)
    `TKSE_ASSERT_IMP(a_idx_idle_zero, i_clk, i_rst_n, i_q_empty, r_idx == 3'd0)
    `TKSE_ASSERT_NXT(a_idx_restart, i_clk, i_rst_n, o_q_pop, r_idx == 3'd0)
    `TKSE_ASSERT_NXT(a_last_on_pop, i_clk, i_rst_n, o_q_pop, r_out_valid && r_out.last_byte)

endmodule

/* hdl/terminal_key_sequence_encoder_top.sv */
// Top level of the terminal key sequence encoder.
// Depends on tkse_pkg, tkse_front, tkse_queue and tkse_back.
//
// Usage:
//   Key items enter through push/full: an item is taken at a clock edge where
//   push is high and full is low. Each item is a key code, a code point and a
//   Shift/Alt/Ctrl mask. Results leave through empty/pop, one byte per result,
//   with last_byte set on the final byte of each key's sequence.
//   Keys with no sequence (none or unknown codes) are taken and give nothing.
//   i_cfg_we/i_cfg_wdata write the cursor application mode bit; write it only
//   while no key is in flight.
// Timing:
//   The first byte of a key is registered in the queue, then in the output
//   register, before it appears. The back end emits one byte a cycle while
//   the output register is empty or being popped, walking a key of one to
//   seven bytes out byte by byte; that byte walk sets the sustained rate.
//   The front takes an item every cycle while the inner queue has room.
// Reset clears the queue, the output register and the mode bit. When pop is
//   held low the output byte holds, the back end stops, the queue fills and
//   full then holds further items off.
module terminal_key_sequence_encoder_top #(
    parameter int QUEUE_DEPTH = tkse_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           push,
    output logic           full,
    input  tkse_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output tkse_pkg::t_out o_result
);

    logic           w_q_full;
    logic           w_q_empty;
    logic           w_q_push;
    logic           w_q_pop;
    tkse_pkg::t_cmd w_cmd;
    tkse_pkg::t_cmd w_head;

    tkse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (w_q_full),
        .o_full      (full),
        .o_q_push    (w_q_push),
        .o_cmd       (w_cmd)
    );

    tkse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    tkse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

/* bench/terminal_key_sequence_encoder_top_tb.sv */
// Self-checking bench for the terminal key sequence encoder: directed keys, then random keys
// in both cursor modes, with random push and pop idling on either side.
// Depends on tkse_pkg and terminal_key_sequence_encoder_top.
`timescale 1ns / 1ps

module terminal_key_sequence_encoder_top_tb;

    localparam logic [4:0] KEY_NONE    = 5'd0;
    localparam logic [4:0] KEY_END     = 5'd11;
    localparam logic [4:0] KEY_F1      = 5'd12;
    localparam logic [4:0] KEY_F4      = 5'd15;
    localparam logic [4:0] KEY_DELETE  = 5'd18;
    localparam logic [4:0] KEY_UNKNOWN = 5'd29;
    localparam logic [4:0] KEY_TOP     = 5'd31;

    localparam logic [2:0] M_NONE  = 3'd0;
    localparam logic [2:0] M_SHIFT = 3'd1;
    localparam logic [2:0] M_ALT   = 3'd2;
    localparam logic [2:0] M_CTRL  = 3'd4;
    localparam logic [2:0] M_ALL   = 3'd7;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_HT  = 8'h09;
    localparam logic [7:0] BYTE_DEL = 8'h7F;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        tkse_pkg::t_in item;
        int            n;     // -1: left to the predictor
        logic [55:0]   seq;   // typed bytes, last byte in the low bits
    } t_key_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic           i_cfg_wdata = 1'b0;
    logic           push = 1'b0;
    logic           full;
    tkse_pkg::t_in  i_item = '0;
    logic           empty;
    logic           pop = 1'b0;
    tkse_pkg::t_out o_result;

    tkse_pkg::t_out pending_bytes[$];
    t_key_row       key_table[$];
    bit             app_mode = 1'b0;
    bit             calm = 1'b0;
    int             pop_hold = 0;
    int             idle_cycles = 0;
    int             mismatch_count = 0;
    tkse_pkg::t_out want;

    terminal_key_sequence_encoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_key_row key_row(input logic [4:0] key, input logic [20:0] cp,
                                         input logic [2:0] mods, input int n,
                                         input logic [55:0] seq);
        t_key_row r;
        r.item.key_code      = key;
        r.item.code_point    = cp;
        r.item.modifier_mask = mods;
        r.n   = n;
        r.seq = seq;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none at all while calm.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void put_decimal(input int v, inout logic [7:0] bq[$]);
        if (v >= 10)
            bq.push_back(tkse_pkg::BYTE_ZERO + 8'(v / 10));
        bq.push_back(tkse_pkg::BYTE_ZERO + 8'(v % 10));
    endfunction

    // Works out the byte sequence of one key and queues it.
    function automatic void expect_key_bytes(input tkse_pkg::t_in k);
        logic [7:0]     bq[$];
        logic [7:0]     finals[11];
        int             tilde_codes[12];
        logic [20:0]    cp;
        logic [2:0]     mods;
        int             idx;
        tkse_pkg::t_out r;
        finals = '{"A", "B", "C", "D", "H", "F", "P", "Q", "R", "S", "Z"};
        tilde_codes = '{2, 3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
        cp   = k.code_point;
        mods = k.modifier_mask;
        if (k.key_code == tkse_pkg::KEY_CHAR) begin
            if (mods[tkse_pkg::MOD_ALT])
                bq.push_back(tkse_pkg::BYTE_ESC);
            if (mods[tkse_pkg::MOD_CTRL] && cp >= "a" && cp <= "z") begin
                bq.push_back(cp[7:0] - "a" + 8'd1);
            end else if (mods[tkse_pkg::MOD_CTRL] && cp >= "A" && cp <= "Z") begin
                bq.push_back(cp[7:0] - "A" + 8'd1);
            end else if (mods[tkse_pkg::MOD_CTRL] && cp == " ") begin
                bq.push_back(8'h00);
            end else begin
                if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
                    cp = 21'hFFFD;
                if (cp < 21'h80) begin
                    bq.push_back(cp[7:0]);
                end else if (cp < 21'h800) begin
                    bq.push_back({3'b110, cp[10:6]});
                    bq.push_back({2'b10, cp[5:0]});
                end else if (cp < 21'h10000) begin
                    bq.push_back({4'b1110, cp[15:12]});
                    bq.push_back({2'b10, cp[11:6]});
                    bq.push_back({2'b10, cp[5:0]});
                end else begin
                    bq.push_back({5'b11110, cp[20:18]});
                    bq.push_back({2'b10, cp[17:12]});
                    bq.push_back({2'b10, cp[11:6]});
                    bq.push_back({2'b10, cp[5:0]});
                end
            end
        end else if (k.key_code >= tkse_pkg::KEY_ENTER &&
                     k.key_code <= tkse_pkg::KEY_ESCAPE) begin
            if (mods[tkse_pkg::MOD_ALT])
                bq.push_back(tkse_pkg::BYTE_ESC);
            case (k.key_code)
                tkse_pkg::KEY_ENTER:     bq.push_back(BYTE_CR);
                tkse_pkg::KEY_TAB:       bq.push_back(BYTE_HT);
                tkse_pkg::KEY_BACKSPACE: bq.push_back(BYTE_DEL);
                default:                 bq.push_back(tkse_pkg::BYTE_ESC);
            endcase
        end else if (k.key_code >= tkse_pkg::KEY_UP &&
                     k.key_code <= tkse_pkg::KEY_BACKTAB) begin
            idx = k.key_code - tkse_pkg::KEY_UP;
            bq.push_back(tkse_pkg::BYTE_ESC);
            if (mods != M_NONE) begin
                bq.push_back(tkse_pkg::BYTE_CSI);
                bq.push_back(tkse_pkg::BYTE_ONE);
                bq.push_back(tkse_pkg::BYTE_SEMI);
                put_decimal(mods + 1, bq);
            end else if (k.key_code >= KEY_F1 && k.key_code <= KEY_F4) begin
                bq.push_back(tkse_pkg::BYTE_SS3);
            end else if (k.key_code == tkse_pkg::KEY_BACKTAB) begin
                bq.push_back(tkse_pkg::BYTE_CSI);
            end else begin
                // Plain cursor, Home and End keys follow the cursor mode bit.
                bq.push_back(app_mode ? tkse_pkg::BYTE_SS3 : tkse_pkg::BYTE_CSI);
            end
            bq.push_back(finals[idx]);
        end else if (k.key_code >= tkse_pkg::KEY_INSERT &&
                     k.key_code <= tkse_pkg::KEY_F12) begin
            bq.push_back(tkse_pkg::BYTE_ESC);
            bq.push_back(tkse_pkg::BYTE_CSI);
            put_decimal(tilde_codes[k.key_code - tkse_pkg::KEY_INSERT], bq);
            if (mods != M_NONE) begin
                bq.push_back(tkse_pkg::BYTE_SEMI);
                put_decimal(mods + 1, bq);
            end
            bq.push_back(tkse_pkg::BYTE_TILDE);
        end
        foreach (bq[i]) begin
            r.out_byte  = bq[i];
            r.last_byte = (i == bq.size() - 1);
            pending_bytes.push_back(r);
        end
    endfunction

    function automatic tkse_pkg::t_in random_key();
        tkse_pkg::t_in k;
        int            r;
        r = $urandom_range(99);
        if (r < 5)
            k.key_code = $urandom_range(1) ? KEY_NONE : 5'($urandom_range(KEY_TOP, KEY_UNKNOWN));
        else if (r < 45)
            k.key_code = tkse_pkg::KEY_CHAR;
        else
            k.key_code = 5'($urandom_range(tkse_pkg::KEY_F12, tkse_pkg::KEY_ENTER));
        case ($urandom_range(9))
            0:       k.code_point = 21'($urandom_range("z", "a"));
            1:       k.code_point = 21'($urandom_range("Z", "A"));
            2:       k.code_point = " ";
            3:       k.code_point = 21'($urandom_range(21'h7F, 0));
            4:       k.code_point = 21'($urandom_range(21'h7FF, 21'h80));
            5:       k.code_point = 21'($urandom_range(21'hFFFF, 21'h800));
            6:       k.code_point = 21'($urandom_range(21'h10FFFF, 21'h10000));
            7:       k.code_point = 21'($urandom_range(21'hDFFF, 21'hD800));
            8:       k.code_point = 21'($urandom_range(21'h1FFFFF, 21'h110000));
            default: k.code_point = 21'($urandom);
        endcase
        k.modifier_mask = 3'($urandom_range(M_ALL));
        return k;
    endfunction

    // Offers one key until it is taken, then queues what it should produce.
    task automatic send_key(input tkse_pkg::t_in k, input int typed_n,
                            input logic [55:0] typed_seq);
        int             gap;
        tkse_pkg::t_out r;
        push   <= 1'b1;
        i_item <= k;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (typed_n < 0) begin
            expect_key_bytes(k);
        end else begin
            for (int i = 0; i < typed_n; i++) begin
                r.out_byte  = typed_seq[8 * (typed_n - 1 - i) +: 8];
                r.last_byte = (i == typed_n - 1);
                pending_bytes.push_back(r);
            end
        end
        gap = idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Keys that produce nothing may still be in flight when the last byte arrives.
    task automatic drain(input int extra);
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_cursor_mode(input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        app_mode = v;
    endtask

    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(3) == 0)
                pop_hold <= idle_len();
        end
        if ($urandom_range(199) == 0)
            calm <= !calm;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected item: out_byte %h last_byte %b",
                       o_result.out_byte, o_result.last_byte);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_result.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_result.out_byte);
                    mismatch_count++;
                end
                if (o_result.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %b, got %b",
                           want.last_byte, o_result.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $error("no progress for %0d cycles, %0d bytes outstanding",
                       idle_cycles, pending_bytes.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        key_table.push_back(key_row(KEY_NONE, 21'h0, M_NONE, 0, 56'h0));
        key_table.push_back(key_row(KEY_UNKNOWN, 21'h61, M_NONE, 0, 56'h0));
        key_table.push_back(key_row(KEY_TOP, 21'h1FFFFF, M_ALL, 0, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, "a", M_NONE, 1, 56'h61));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h0, M_NONE, 1, 56'h00));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h1FFFFF, M_NONE, 3, 56'hEFBFBD));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'hD800, M_SHIFT, 3, 56'hEFBFBD));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'hDFFF, M_NONE, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h10FFFF, M_NONE, 4, 56'hF48FBFBF));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, "z", M_CTRL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, "A", M_ALL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, " ", M_CTRL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'hE9, M_CTRL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h7FF, M_SHIFT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h800, M_ALT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_CHAR, 21'h1F600, M_ALT | M_CTRL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_ENTER, 21'h0, M_ALT, 2, 56'h1B0D));
        key_table.push_back(key_row(tkse_pkg::KEY_TAB, 21'h0, M_CTRL, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_BACKSPACE, 21'h0, M_SHIFT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_ESCAPE, 21'h0, M_ALT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_UP, 21'h0, M_NONE, 3, 56'h1B5B41));
        key_table.push_back(key_row(KEY_END, 21'h0, M_ALL, 6, 56'h1B5B313B3846));
        key_table.push_back(key_row(KEY_F1, 21'h0, M_NONE, -1, 56'h0));
        key_table.push_back(key_row(KEY_F4, 21'h0, M_SHIFT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_BACKTAB, 21'h0, M_NONE, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_INSERT, 21'h0, M_NONE, -1, 56'h0));
        key_table.push_back(key_row(KEY_DELETE, 21'h0, M_ALT, -1, 56'h0));
        key_table.push_back(key_row(tkse_pkg::KEY_F12, 21'h0, M_ALL, 7, 56'h1B5B32343B387E));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The mode bit is still at its reset value for the directed keys.
        foreach (key_table[i])
            send_key(key_table[i].item, key_table[i].n, key_table[i].seq);

        for (int phase = 0; phase < 4; phase++) begin
            drain(8);
            set_cursor_mode(phase % 2 == 0);
            repeat (ITEMS_PER_PHASE)
                send_key(random_key(), -1, 56'h0);
        end

        drain(20);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* terminal_key_sequence_encoder_top.f */
+incdir+hdl
hdl/tkse_pkg.sv
hdl/tkse_front.sv
hdl/tkse_queue.sv
hdl/tkse_back.sv
hdl/terminal_key_sequence_encoder_top.sv
bench/terminal_key_sequence_encoder_top_tb.sv
